### sv/cfc_pkg.sv
// shared constants and types for the ascii command frame checker
// no dependencies; used by cfc_result_if, the frame tracker and the top level
package cfc_pkg;

  // frame characters
  localparam logic [7:0] START_CHAR = 8'h3E;
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // checksum floor and minimum frame length
  localparam logic [7:0] SUM_FLOOR = 8'd16;
  localparam int unsigned MIN_FRAME = 4;

  // overflow limits
  localparam int unsigned MAX_FIELDS    = 12;
  localparam int unsigned MAX_FIELD_LEN = 256;
  localparam int unsigned MAX_FRAME_LEN = 3072;

  // counter widths
  localparam int unsigned FIELD_CNT_W = 4;
  localparam int unsigned FIELD_LEN_W = 9;
  localparam int unsigned FRAME_LEN_W = 12;

  // result kind
  typedef enum logic {
    KIND_PARAM   = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // verdict codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SUM   = 2'd1,
    STATUS_TOO_SHORT = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  // one result transaction
  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             data_byte;
    logic [FIELD_CNT_W-1:0] param_index;
    status_t                status;
  } result_t;

endpackage

### sv/cfc_byte_if.sv
// valid/ready channel carrying one received byte
// depends on nothing
interface cfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/cfc_result_if.sv
// valid/ready channel carrying one parameter byte or frame verdict
// depends on cfc_pkg for the field widths
interface cfc_result_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [7:0]                      data_byte;
  logic [cfc_pkg::FIELD_CNT_W-1:0] param_index;
  logic [1:0]                      status;

  modport source (output valid, output kind, output data_byte, output param_index,
                  output status, input ready);
  modport sink   (input valid, input kind, input data_byte, input param_index,
                  input status, output ready);
endinterface

### sv/cfc_frame_tracker.sv
// frame state, checksum and counters; one byte processed per strobe
// depends on cfc_pkg
module cfc_frame_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             strobe,
  input  logic [7:0]       rx_byte,
  output logic             has_result,
  output cfc_pkg::result_t result
);

  logic                            in_frame, in_frame_next;
  logic [7:0]                      held_byte, held_byte_next;
  logic                            held_valid, held_valid_next;
  logic                            last_was_space, last_was_space_next;
  logic [7:0]                      running_sum, running_sum_next;
  logic [cfc_pkg::FIELD_CNT_W-1:0] field_count, field_count_next;
  logic [cfc_pkg::FIELD_LEN_W-1:0] field_length, field_length_next;
  logic [cfc_pkg::FRAME_LEN_W-1:0] frame_length, frame_length_next;
  logic                            overflow_seen, overflow_seen_next;

  logic [7:0]       floored_sum;
  cfc_pkg::status_t verdict;

  // checksum with floor and verdict priority
  always_comb begin
    if (running_sum < cfc_pkg::SUM_FLOOR) begin
      floored_sum = running_sum + cfc_pkg::SUM_FLOOR;
    end else begin
      floored_sum = running_sum;
    end
    if (frame_length < cfc_pkg::FRAME_LEN_W'(cfc_pkg::MIN_FRAME)) begin
      verdict = cfc_pkg::STATUS_TOO_SHORT;
    end else if (overflow_seen) begin
      verdict = cfc_pkg::STATUS_OVERFLOW;
    end else if (held_valid && (floored_sum == held_byte)) begin
      verdict = cfc_pkg::STATUS_OK;
    end else begin
      verdict = cfc_pkg::STATUS_BAD_SUM;
    end
  end

  // next state and result
  always_comb begin
    in_frame_next       = in_frame;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    last_was_space_next = last_was_space;
    running_sum_next    = running_sum;
    field_count_next    = field_count;
    field_length_next   = field_length;
    frame_length_next   = frame_length;
    overflow_seen_next  = overflow_seen;
    has_result          = 1'b0;
    result.kind         = cfc_pkg::KIND_PARAM;
    result.data_byte    = held_byte;
    result.param_index  = field_count;
    result.status       = cfc_pkg::STATUS_OK;

    if (strobe) begin
      if (!in_frame) begin
        // waiting for start; open a fresh frame on '>'
        if (rx_byte == cfc_pkg::START_CHAR) begin
          in_frame_next       = 1'b1;
          held_byte_next      = 8'd0;
          held_valid_next     = 1'b0;
          last_was_space_next = 1'b0;
          running_sum_next    = cfc_pkg::START_CHAR;
          field_count_next    = '0;
          field_length_next   = '0;
          frame_length_next   = '0;
          overflow_seen_next  = 1'b0;
        end
      end else if (rx_byte == cfc_pkg::LINE_FEED) begin
        // end of frame: give the verdict and return to idle
        has_result          = 1'b1;
        result.kind         = cfc_pkg::KIND_VERDICT;
        result.data_byte    = 8'd0;
        result.param_index  = field_count;
        result.status       = verdict;
        in_frame_next       = 1'b0;
        held_byte_next      = 8'd0;
        held_valid_next     = 1'b0;
        last_was_space_next = 1'b0;
        running_sum_next    = cfc_pkg::START_CHAR;
        field_count_next    = '0;
        field_length_next   = '0;
        frame_length_next   = '0;
        overflow_seen_next  = 1'b0;
      end else begin
        // frame length, saturating
        if (frame_length >= cfc_pkg::FRAME_LEN_W'(cfc_pkg::MAX_FRAME_LEN)) begin
          overflow_seen_next = 1'b1;
        end else begin
          frame_length_next = frame_length + 1'b1;
        end
        // release the held byte
        if (held_valid) begin
          if (held_byte == cfc_pkg::SPACE_CHAR) begin
            if (!last_was_space) begin
              if (field_count < cfc_pkg::FIELD_CNT_W'(cfc_pkg::MAX_FIELDS)) begin
                field_count_next  = field_count + 1'b1;
                field_length_next = '0;
                running_sum_next  = running_sum + cfc_pkg::SPACE_CHAR;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            last_was_space_next = 1'b1;
          end else begin
            last_was_space_next = 1'b0;
            if (field_length >= cfc_pkg::FIELD_LEN_W'(cfc_pkg::MAX_FIELD_LEN)) begin
              overflow_seen_next = 1'b1;
            end else begin
              field_length_next = field_length + 1'b1;
            end
            running_sum_next = running_sum + held_byte;
            has_result       = 1'b1;
          end
        end
        held_byte_next  = rx_byte;
        held_valid_next = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      held_byte      <= 8'd0;
      held_valid     <= 1'b0;
      last_was_space <= 1'b0;
      running_sum    <= cfc_pkg::START_CHAR;
      field_count    <= '0;
      field_length   <= '0;
      frame_length   <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      in_frame       <= in_frame_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      last_was_space <= last_was_space_next;
      running_sum    <= running_sum_next;
      field_count    <= field_count_next;
      field_length   <= field_length_next;
      frame_length   <= frame_length_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

endmodule

### sv/ascii_command_frame_checker_core.sv
// top level of the ascii command frame checker: input register, frame tracker, result register
// depends on cfc_pkg, cfc_byte_if, cfc_result_if and cfc_frame_tracker
//
// The block takes one received byte per clock unless stalled and gives at most one result per
// byte: a parameter character with its parameter index, or a verdict at line feed. Each byte
// passes through the input register into the frame tracker, and each result is held in the
// result register; sustained throughput is one byte per cycle while the result side
// keeps taking transactions. The input and result registers each hold one transaction and
// advance together, so a stall on the result channel holds off new bytes only once both
// are full. Bytes outside a frame are dropped without a result.
module ascii_command_frame_checker_core (
  input logic          clk,
  input logic          rst,
  cfc_byte_if.sink     rx,
  cfc_result_if.source result
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_valid;
  cfc_pkg::result_t out_data;
  logic             advance;
  logic             has_result;
  cfc_pkg::result_t new_result;

  // the input register moves on when the result register has room
  assign advance  = in_valid && (!out_valid || result.ready);
  assign rx.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // frame state and result logic
  cfc_frame_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .strobe     (advance),
    .rx_byte    (in_byte),
    .has_result (has_result),
    .result     (new_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data <= new_result;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_data.kind;
  assign result.data_byte   = out_data.data_byte;
  assign result.param_index = out_data.param_index;
  assign result.status      = out_data.status;

endmodule
